// File: rtl/mlsf_pkg.sv
`default_nettype none
package mlsf_pkg;
    localparam int MaxSpan   = 1024;
    localparam int BandCount = 6;
    localparam int AddrW     = $clog2(MaxSpan);
    localparam int PosW      = 11;
    localparam int LogW      = 20;
    localparam int SumW      = 32;
    localparam int GainW     = 24;
    localparam int CfgIdxW   = 3;

    localparam logic [CfgIdxW-1:0] RegEdgeOne   = 3'd0;
    localparam logic [CfgIdxW-1:0] RegEdgeTwo   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegEdgeThree = 3'd2;
    localparam logic [CfgIdxW-1:0] RegEdgeFour  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegEdgeFive  = 3'd4;
    localparam logic [CfgIdxW-1:0] RegSpan      = 3'd5;
    localparam logic [CfgIdxW-1:0] RegGain      = 3'd6;

    localparam logic [31:0] Ln2Q32 = 32'd2977044472;
    localparam logic [LogW-1:0] LogMax = {LogW{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQR, ST_SQI, ST_ROOT, ST_MUL, ST_NORM,
        ST_LOG, ST_LNMUL, ST_LNRND, ST_UPD, ST_DONE
    } mlsf_state_t;
endpackage
`default_nettype wire

// File: rtl/mlsf_ram.sv
`default_nettype none
module mlsf_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire [WIDTH-1:0]          wr_data,
    input  wire                      rd_en,
    input  wire [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/multiband_log_spectral_flux.sv
`default_nettype none
// Multiband log spectral flux. Each item is one complex FFT bin of the configured
// span; the block forms log(1 + gain*|X|) in Q4.16, stores it over the previous
// frame's value at that offset and adds the positive rise into the band sums.
// The frame's last bin yields one item with six Q16.16 saturating band sums,
// except for the first frame of a stream. One item is processed at a time: a new
// bin is accepted only when the last is through, after any wait for the result
// port at a frame's last bin. Its steps are a 24-step bit-serial square root, a
// one-bit-per-cycle normalize and 24 log2 squaring steps through one 32x32
// multiplier. Previous magnitudes live in a 1024 x 20 RAM.
module multiband_log_spectral_flux (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [47:0]                       s_tdata,  // bin_real, bin_imag
    input  wire                               s_tuser,  // new_stream
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [191:0]                      m_tdata,  // band_flux_0 .. band_flux_5
    input  wire                               cfg_wr_en,
    input  wire  [mlsf_pkg::CfgIdxW-1:0]      cfg_wr_index,
    input  wire  [mlsf_pkg::GainW-1:0]        cfg_wr_data
);
    import mlsf_pkg::*;

    mlsf_state_t state_reg, state_next;

    logic [PosW-1:0]  edge_reg [5];
    logic [PosW-1:0]  span_reg;
    logic [GainW-1:0] gain_reg;

    logic signed [23:0] re_reg, im_reg;
    logic [47:0]      v_reg, res_reg;
    logic [4:0]       k_reg;
    logic [48:0]      x_reg;
    logic [5:0]       e_reg;
    logic [31:0]      m_reg;
    logic [23:0]      frac_reg;
    logic [62:0]      prod_reg;
    logic [LogW-1:0]  cur_reg, prev_reg;
    logic [AddrW-1:0] pos_reg, bin_position_reg;
    logic             have_prev_reg, last_reg;
    logic [SumW-1:0]  sum_reg [BandCount];
    logic [SumW-1:0]  out_reg [BandCount];
    logic             m_tvalid_reg;

    logic [PosW-1:0]  len;
    logic [PosW-1:0]  pos_start;
    logic [PosW-1:0]  edges [BandCount+1];
    logic             accept;
    logic [47:0]      trial;
    logic [63:0]      sq;
    logic [32:0]      msq;
    logic [LogW-1:0]  ram_rd_data;
    logic             ram_we;
    logic [LogW-1:0]  d;
    logic [22:0]      ln_full;
    logic [SumW:0]    acc [BandCount];

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign ram_we   = (state_reg == ST_UPD);

    always_comb begin
        if (span_reg == '0) begin
            len = PosW'(1);
        end else if (span_reg > PosW'(MaxSpan)) begin
            len = PosW'(MaxSpan);
        end else begin
            len = span_reg;
        end
        pos_start = s_tuser ? '0 : {1'b0, bin_position_reg};
        if (pos_start >= len) begin
            pos_start = len - PosW'(1);
        end
        edges[0] = '0;
        for (int b = 0; b < 5; b++) begin
            edges[b+1] = edge_reg[b];
        end
        edges[BandCount] = span_reg;
        trial   = res_reg + (48'd1 << {k_reg, 1'b0});
        sq      = m_reg * m_reg;
        msq     = sq[63:31];
        ln_full = 23'((prod_reg + (63'd1 << 39)) >> 40);
        d       = (have_prev_reg && cur_reg > prev_reg) ? cur_reg - prev_reg : '0;
        for (int b = 0; b < BandCount; b++) begin
            acc[b] = {1'b0, sum_reg[b]} + (SumW+1)'(d);
        end
    end

    genvar g;
    for (g = 0; g < BandCount; g++) begin : g_out
        assign m_tdata[g*SumW +: SumW] = out_reg[g];
    end

    mlsf_ram #(.WIDTH(LogW), .DEPTH(MaxSpan)) u_prev_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (pos_reg),
        .wr_data (cur_reg),
        .rd_en   (accept),
        .rd_addr (pos_start[AddrW-1:0]),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_SQR;
            ST_SQR:   state_next = ST_SQI;
            ST_SQI:   state_next = ST_ROOT;
            ST_ROOT:  if (k_reg == '0) state_next = ST_MUL;
            ST_MUL:   state_next = ST_NORM;
            ST_NORM:  if (x_reg[48]) state_next = ST_LOG;
            ST_LOG:   if (k_reg == '0) state_next = ST_LNMUL;
            ST_LNMUL: state_next = ST_LNRND;
            ST_LNRND: state_next = ST_UPD;
            ST_UPD:   state_next = ST_DONE;
            ST_DONE: begin
                if (!(last_reg && have_prev_reg) || !m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_reg[0]      <= PosW'(7);
            edge_reg[1]      <= PosW'(16);
            edge_reg[2]      <= PosW'(35);
            edge_reg[3]      <= PosW'(72);
            edge_reg[4]      <= PosW'(146);
            span_reg         <= PosW'(369);
            gain_reg         <= GainW'(3200);
            bin_position_reg <= '0;
            have_prev_reg    <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            for (int b = 0; b < BandCount; b++) begin
                sum_reg[b] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    RegEdgeOne:   edge_reg[0] <= cfg_wr_data[PosW-1:0];
                    RegEdgeTwo:   edge_reg[1] <= cfg_wr_data[PosW-1:0];
                    RegEdgeThree: edge_reg[2] <= cfg_wr_data[PosW-1:0];
                    RegEdgeFour:  edge_reg[3] <= cfg_wr_data[PosW-1:0];
                    RegEdgeFive:  edge_reg[4] <= cfg_wr_data[PosW-1:0];
                    RegSpan:      span_reg    <= cfg_wr_data[PosW-1:0];
                    RegGain:      gain_reg    <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_DONE && state_next == ST_IDLE && last_reg && have_prev_reg) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (accept && s_tuser) begin
                have_prev_reg <= 1'b0;
                for (int b = 0; b < BandCount; b++) begin
                    sum_reg[b] <= '0;
                end
            end
            if (state_reg == ST_UPD) begin
                for (int b = 0; b < BandCount; b++) begin
                    if ({1'b0, pos_reg} >= edges[b] && {1'b0, pos_reg} < edges[b+1]) begin
                        sum_reg[b] <= acc[b][SumW] ? {SumW{1'b1}} : acc[b][SumW-1:0];
                    end
                end
            end
            if (state_reg == ST_DONE && state_next == ST_IDLE) begin
                if (last_reg) begin
                    if (have_prev_reg) begin
                        for (int b = 0; b < BandCount; b++) begin
                            out_reg[b] <= sum_reg[b];
                        end
                    end
                    for (int b = 0; b < BandCount; b++) begin
                        sum_reg[b] <= '0;
                    end
                    bin_position_reg <= '0;
                    have_prev_reg    <= 1'b1;
                end else begin
                    bin_position_reg <= pos_reg + AddrW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                re_reg   <= s_tdata[23:0];
                im_reg   <= s_tdata[47:24];
                pos_reg  <= pos_start[AddrW-1:0];
                last_reg <= (pos_start + PosW'(1)) >= len;
            end
            ST_SQR: begin
                v_reg    <= 48'(re_reg * re_reg);
                prev_reg <= ram_rd_data;
            end
            ST_SQI: begin
                v_reg   <= v_reg + 48'(im_reg * im_reg);
                res_reg <= '0;
                k_reg   <= 5'd23;
            end
            ST_ROOT: begin
                if (v_reg >= trial) begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + (48'd1 << {k_reg, 1'b0});
                end else begin
                    res_reg <= res_reg >> 1;
                end
                k_reg <= k_reg - 5'd1;
            end
            ST_MUL: begin
                x_reg <= 49'(65536) + 49'(gain_reg * res_reg[23:0]);
                e_reg <= 6'd48;
            end
            ST_NORM: begin
                if (!x_reg[48]) begin
                    x_reg <= x_reg << 1;
                    e_reg <= e_reg - 6'd1;
                end else begin
                    m_reg    <= x_reg[48:17];
                    frac_reg <= '0;
                    k_reg    <= 5'd23;
                end
            end
            ST_LOG: begin
                frac_reg <= {frac_reg[22:0], msq[32]};
                m_reg    <= msq[32] ? msq[32:1] : msq[31:0];
                k_reg    <= k_reg - 5'd1;
            end
            ST_LNMUL: begin
                prod_reg <= 63'({6'(e_reg - 6'd16), frac_reg} * Ln2Q32);
            end
            ST_LNRND: begin
                cur_reg <= (ln_full > 23'(LogMax)) ? LogMax : ln_full[LogW-1:0];
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_SQR) else $error("accept did not start work");
    a_ram_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> $past(state_reg) == ST_LNRND) else $error("stray store write");
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UPD |-> {1'b0, pos_reg} < len) else $error("position past span");
`endif
endmodule
`default_nettype wire
